### hdl/offset_point_unicycle_controller_unit_defines.svh
// Assertion macros shared by the offset-point controller RTL.
`ifndef OFFSET_POINT_UNICYCLE_CONTROLLER_UNIT_DEFINES_SVH
`define OFFSET_POINT_UNICYCLE_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define OPUC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define OPUC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/opuc_pkg.sv
// Types, constants and tables of the offset-point unicycle controller.
`timescale 1ns / 1ps

package opuc_pkg;

  localparam int DATA_W = 16;
  localparam int ANGLE_W = 16;

  // Sine and cosine are signed Q2.14 clamped to plus or minus one.
  localparam int TRIG_W = 16;
  localparam int TRIG_ONE = 16384;
  localparam int TRIG_FRAC = 14;

  localparam int CORDIC_STAGES = 15;
  localparam int CORDIC_XY_W = 18;
  localparam int CORDIC_Z_W = 17;
  localparam int CORDIC_START = 9949;
  localparam int QUARTER_TURN = 16384;
  localparam int HALF_TURN = 32768;

  // Configuration register port.
  localparam int CFG_W = 16;
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_DIST = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_RECIP = 2'd2;

  localparam int GAIN_W = 16;
  localparam int DIST_W = 15;
  localparam int RECIP_W = 16;
  localparam logic [GAIN_W-1:0] PROP_GAIN_RESET = 16'd0;
  localparam logic [DIST_W-1:0] OFFSET_DIST_RESET = 15'd307;
  localparam logic [RECIP_W-1:0] OFFSET_RECIP_RESET = 16'd853;

  localparam logic [DATA_W-1:0] VEL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] VEL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Arctangent of 2^-i in binary-angle units.
  function automatic logic signed [CORDIC_Z_W-1:0] atan_step(input int i);
    logic signed [CORDIC_Z_W-1:0] step;
    case (i)
      0:       step = CORDIC_Z_W'(8192);
      1:       step = CORDIC_Z_W'(4836);
      2:       step = CORDIC_Z_W'(2555);
      3:       step = CORDIC_Z_W'(1297);
      4:       step = CORDIC_Z_W'(651);
      5:       step = CORDIC_Z_W'(326);
      6:       step = CORDIC_Z_W'(163);
      7:       step = CORDIC_Z_W'(81);
      8:       step = CORDIC_Z_W'(41);
      9:       step = CORDIC_Z_W'(20);
      10:      step = CORDIC_Z_W'(10);
      11:      step = CORDIC_Z_W'(5);
      12:      step = CORDIC_Z_W'(3);
      13:      step = CORDIC_Z_W'(1);
      14:      step = CORDIC_Z_W'(1);
      default: step = '0;
    endcase
    return step;
  endfunction

  typedef struct packed {
    logic signed [DATA_W-1:0]  pose_x;
    logic signed [DATA_W-1:0]  pose_y;
    logic signed [ANGLE_W-1:0] heading;
    logic signed [DATA_W-1:0]  target_x;
    logic signed [DATA_W-1:0]  target_y;
  } pose_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] linear_velocity;
    logic signed [DATA_W-1:0] angular_velocity;
    logic                     clipped;
  } vel_t;

  // Positions that ride alongside the sine and cosine pipeline.
  typedef struct packed {
    logic signed [DATA_W-1:0] pose_x;
    logic signed [DATA_W-1:0] pose_y;
    logic signed [DATA_W-1:0] target_x;
    logic signed [DATA_W-1:0] target_y;
  } pos_t;

endpackage

### hdl/opuc_cordic.sv
// Fully pipelined CORDIC that turns a binary angle into sine and cosine.
`timescale 1ns / 1ps

module opuc_cordic (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic signed [opuc_pkg::ANGLE_W-1:0]    angle,
  input  opuc_pkg::pos_t                         side_in,
  output logic                                   out_valid,
  output logic signed [opuc_pkg::TRIG_W-1:0]     cos_val,
  output logic signed [opuc_pkg::TRIG_W-1:0]     sin_val,
  output opuc_pkg::pos_t                         side_out
);

  localparam int N = opuc_pkg::CORDIC_STAGES;
  localparam int XY_W = opuc_pkg::CORDIC_XY_W;
  localparam int Z_W = opuc_pkg::CORDIC_Z_W;

  logic signed [XY_W-1:0] xs [0:N];
  logic signed [XY_W-1:0] ys [0:N];
  logic signed [Z_W-1:0]  zs [0:N];
  logic                   flip [0:N];
  logic                   vld [0:N];
  opuc_pkg::pos_t         side [0:N];

  logic signed [Z_W-1:0]  ang_ext;
  logic signed [Z_W-1:0]  z_fold;
  logic                   fold_flip;

  // Angles beyond a quarter turn are folded by a half turn; the result is negated later.
  always_comb begin
    ang_ext = Z_W'(angle);
    z_fold = ang_ext;
    fold_flip = 1'b0;
    if (ang_ext > Z_W'(opuc_pkg::QUARTER_TURN)) begin
      z_fold = ang_ext - Z_W'(opuc_pkg::HALF_TURN);
      fold_flip = 1'b1;
    end else if (ang_ext < -Z_W'(opuc_pkg::QUARTER_TURN)) begin
      z_fold = ang_ext + Z_W'(opuc_pkg::HALF_TURN);
      fold_flip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      xs[0] <= XY_W'(opuc_pkg::CORDIC_START);
      ys[0] <= '0;
      zs[0] <= z_fold;
      flip[0] <= fold_flip;
      side[0] <= side_in;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic signed [Z_W-1:0] STEP = opuc_pkg::atan_step(i);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        if (zs[i] >= 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - STEP;
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + STEP;
        end
        flip[i+1] <= flip[i];
        side[i+1] <= side[i];
      end
    end
  end

  logic signed [XY_W-1:0]            x_fin;
  logic signed [XY_W-1:0]            y_fin;
  logic signed [opuc_pkg::TRIG_W-1:0] cos_c;
  logic signed [opuc_pkg::TRIG_W-1:0] sin_c;

  always_comb begin
    x_fin = flip[N] ? -xs[N] : xs[N];
    y_fin = flip[N] ? -ys[N] : ys[N];
    if (x_fin > XY_W'(opuc_pkg::TRIG_ONE)) begin
      cos_c = opuc_pkg::TRIG_W'(opuc_pkg::TRIG_ONE);
    end else if (x_fin < -XY_W'(opuc_pkg::TRIG_ONE)) begin
      cos_c = -opuc_pkg::TRIG_W'(opuc_pkg::TRIG_ONE);
    end else begin
      cos_c = x_fin[opuc_pkg::TRIG_W-1:0];
    end
    if (y_fin > XY_W'(opuc_pkg::TRIG_ONE)) begin
      sin_c = opuc_pkg::TRIG_W'(opuc_pkg::TRIG_ONE);
    end else if (y_fin < -XY_W'(opuc_pkg::TRIG_ONE)) begin
      sin_c = -opuc_pkg::TRIG_W'(opuc_pkg::TRIG_ONE);
    end else begin
      sin_c = y_fin[opuc_pkg::TRIG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[N];
    end
    if (en) begin
      cos_val <= cos_c;
      sin_val <= sin_c;
      side_out <= side[N];
    end
  end

endmodule

### hdl/offset_point_unicycle_controller_unit.sv
// Top level of the offset-point unicycle controller.
`timescale 1ns / 1ps
`include "offset_point_unicycle_controller_unit_defines.svh"

// Usage:
// A pose transfer (pose_valid high, pose_stall low) carries the robot's x, y and
// heading and the target x, y. Each one yields exactly one velocity transfer on
// the vel channel: linear and angular velocity, saturated, with clipped set when
// either value had to be limited.
// A pose transfer passes through the sine and cosine CORDIC (fold, fifteen iterations,
// clamp) and then the multiply chain, the last stage of which is the output
// register. Throughput is one item per cycle while vel_stall does not hold back a
// waiting result; every stage is a plain register stage.
// When vel_stall holds back a waiting result, the whole pipeline freezes and
// pose_stall rises in the same cycle; nothing is dropped or repeated.
// The cfg port writes prop_gain, offset_distance or offset_recip at index 0, 1
// or 2; other indexes are ignored. Write it only while no item is in flight.
// A synchronous rst empties the pipeline and restores the register defaults
// (gain 0, d about 0.3 m, 1/d about 3.33).

module offset_point_unicycle_controller_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [opuc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [opuc_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                 pose_valid,
  output logic                                 pose_stall,
  input  opuc_pkg::pose_t                      pose,
  output logic                                 vel_valid,
  input  logic                                 vel_stall,
  output opuc_pkg::vel_t                       vel
);

  localparam int DW = opuc_pkg::DATA_W;
  localparam int TW = opuc_pkg::TRIG_W;
  localparam int FR = opuc_pkg::TRIG_FRAC;
  localparam int P1_W = TW + opuc_pkg::DIST_W + 1;
  localparam int DC_W = P1_W - FR;
  localparam int E_W = ((DW + 1 > DC_W) ? DW + 1 : DC_W) + 1;
  localparam int P3_W = E_W + opuc_pkg::GAIN_W + 1;
  localparam int V_W = P3_W - 8;
  localparam int M_W = V_W + TW;
  localparam int S_W = M_W + 1;
  localparam int R_W = S_W - FR;
  localparam int A_W = R_W + opuc_pkg::RECIP_W + 1;
  localparam int AR_W = A_W - 8;

  logic [opuc_pkg::GAIN_W-1:0]  prop_gain;
  logic [opuc_pkg::DIST_W-1:0]  offset_distance;
  logic [opuc_pkg::RECIP_W-1:0] offset_recip;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain <= opuc_pkg::PROP_GAIN_RESET;
      offset_distance <= opuc_pkg::OFFSET_DIST_RESET;
      offset_recip <= opuc_pkg::OFFSET_RECIP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        opuc_pkg::REG_PROP_GAIN:    prop_gain <= cfg_data[opuc_pkg::GAIN_W-1:0];
        opuc_pkg::REG_OFFSET_DIST:  offset_distance <= cfg_data[opuc_pkg::DIST_W-1:0];
        opuc_pkg::REG_OFFSET_RECIP: offset_recip <= cfg_data[opuc_pkg::RECIP_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves as one whenever the output register can take a new value.
  logic en;
  assign en = !(vel_valid && vel_stall);
  assign pose_stall = !en;

  opuc_pkg::pos_t      side_in;
  opuc_pkg::pos_t      cs_side;
  logic                cs_valid;
  logic signed [TW-1:0] cs_cos;
  logic signed [TW-1:0] cs_sin;

  assign side_in.pose_x = pose.pose_x;
  assign side_in.pose_y = pose.pose_y;
  assign side_in.target_x = pose.target_x;
  assign side_in.target_y = pose.target_y;

  opuc_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (pose_valid),
    .angle    (pose.heading),
    .side_in  (side_in),
    .out_valid(cs_valid),
    .cos_val  (cs_cos),
    .sin_val  (cs_sin),
    .side_out (cs_side)
  );

  // Stage 1: d*cos and d*sin.
  logic                  s1_valid;
  logic signed [P1_W-1:0] s1_dc;
  logic signed [P1_W-1:0] s1_ds;
  logic signed [TW-1:0]  s1_cos;
  logic signed [TW-1:0]  s1_sin;
  opuc_pkg::pos_t        s1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= cs_valid;
    end
    if (en) begin
      s1_dc <= $signed({1'b0, offset_distance}) * cs_cos;
      s1_ds <= $signed({1'b0, offset_distance}) * cs_sin;
      s1_cos <= cs_cos;
      s1_sin <= cs_sin;
      s1_side <= cs_side;
    end
  end

  // Stage 2: position error of the offset point.
  logic signed [P1_W-1:0] dc_rnd;
  logic signed [P1_W-1:0] ds_rnd;
  logic signed [E_W-1:0]  e0_c;
  logic signed [E_W-1:0]  e1_c;

  // Taking the upper bits of a signed sum is a floor shift, so this rounds half up.
  always_comb begin
    dc_rnd = s1_dc + P1_W'(1 << (FR - 1));
    ds_rnd = s1_ds + P1_W'(1 << (FR - 1));
    e0_c = E_W'($signed(s1_side.target_x)) - E_W'($signed(s1_side.pose_x))
         - E_W'($signed(dc_rnd[P1_W-1:FR]));
    e1_c = E_W'($signed(s1_side.target_y)) - E_W'($signed(s1_side.pose_y))
         - E_W'($signed(ds_rnd[P1_W-1:FR]));
  end

  logic                  s2_valid;
  logic signed [E_W-1:0] s2_e0;
  logic signed [E_W-1:0] s2_e1;
  logic signed [TW-1:0]  s2_cos;
  logic signed [TW-1:0]  s2_sin;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
    if (en) begin
      s2_e0 <= e0_c;
      s2_e1 <= e1_c;
      s2_cos <= s1_cos;
      s2_sin <= s1_sin;
    end
  end

  // Stage 3: gain times error.
  logic                   s3_valid;
  logic signed [P3_W-1:0] s3_ke0;
  logic signed [P3_W-1:0] s3_ke1;
  logic signed [TW-1:0]   s3_cos;
  logic signed [TW-1:0]   s3_sin;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
    if (en) begin
      s3_ke0 <= $signed({1'b0, prop_gain}) * s2_e0;
      s3_ke1 <= $signed({1'b0, prop_gain}) * s2_e1;
      s3_cos <= s2_cos;
      s3_sin <= s2_sin;
    end
  end

  // Stage 4: round to Q18.10 and rotate back into the body frame.
  logic signed [P3_W-1:0] ke0_rnd;
  logic signed [P3_W-1:0] ke1_rnd;
  logic signed [V_W-1:0]  v0_c;
  logic signed [V_W-1:0]  v1_c;

  always_comb begin
    ke0_rnd = s3_ke0 + P3_W'(128);
    ke1_rnd = s3_ke1 + P3_W'(128);
    v0_c = ke0_rnd[P3_W-1:8];
    v1_c = ke1_rnd[P3_W-1:8];
  end

  logic                  s4_valid;
  logic signed [M_W-1:0] s4_cv0;
  logic signed [M_W-1:0] s4_sv1;
  logic signed [M_W-1:0] s4_cv1;
  logic signed [M_W-1:0] s4_sv0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
    if (en) begin
      s4_cv0 <= s3_cos * v0_c;
      s4_sv1 <= s3_sin * v1_c;
      s4_cv1 <= s3_cos * v1_c;
      s4_sv0 <= s3_sin * v0_c;
    end
  end

  // Stage 5: rotated sums, rounded to Q21.10.
  logic signed [S_W-1:0] lin_sum;
  logic signed [S_W-1:0] rot_sum;

  always_comb begin
    lin_sum = S_W'(s4_cv0) + S_W'(s4_sv1) + S_W'(1 << (FR - 1));
    rot_sum = S_W'(s4_cv1) - S_W'(s4_sv0) + S_W'(1 << (FR - 1));
  end

  logic                  s5_valid;
  logic signed [R_W-1:0] s5_lin;
  logic signed [R_W-1:0] s5_rot;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en) begin
      s5_valid <= s4_valid;
    end
    if (en) begin
      s5_lin <= lin_sum[S_W-1:FR];
      s5_rot <= rot_sum[S_W-1:FR];
    end
  end

  // Stage 6: angular term times 1/d.
  logic                  s6_valid;
  logic signed [A_W-1:0] s6_ang;
  logic signed [R_W-1:0] s6_lin;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else if (en) begin
      s6_valid <= s5_valid;
    end
    if (en) begin
      s6_ang <= s5_rot * $signed({1'b0, offset_recip});
      s6_lin <= s5_lin;
    end
  end

  // Stage 7: round, saturate and load the output register.
  logic signed [A_W-1:0] ang_rnd;
  logic [AR_W-1:0]       ang_c;
  logic                  lin_ovf;
  logic                  ang_ovf;
  logic [DW-1:0]         lin_sat;
  logic [DW-1:0]         ang_sat;

  // A value fits when all bits from the output sign bit upward agree.
  always_comb begin
    ang_rnd = s6_ang + A_W'(128);
    ang_c = ang_rnd[A_W-1:8];
    lin_ovf = !((&s6_lin[R_W-1:DW-1]) || !(|s6_lin[R_W-1:DW-1]));
    ang_ovf = !((&ang_c[AR_W-1:DW-1]) || !(|ang_c[AR_W-1:DW-1]));
    if (lin_ovf) begin
      lin_sat = s6_lin[R_W-1] ? opuc_pkg::VEL_MIN : opuc_pkg::VEL_MAX;
    end else begin
      lin_sat = s6_lin[DW-1:0];
    end
    if (ang_ovf) begin
      ang_sat = ang_c[AR_W-1] ? opuc_pkg::VEL_MIN : opuc_pkg::VEL_MAX;
    end else begin
      ang_sat = ang_c[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vel_valid <= 1'b0;
    end else if (en) begin
      vel_valid <= s6_valid;
    end
    if (en) begin
      vel.linear_velocity <= lin_sat;
      vel.angular_velocity <= ang_sat;
      vel.clipped <= lin_ovf || ang_ovf;
    end
  end

  `OPUC_ASSERT_NOW(a_clip_at_limit,
    vel_valid && vel.clipped,
    vel.linear_velocity == opuc_pkg::VEL_MAX || vel.linear_velocity == opuc_pkg::VEL_MIN ||
    vel.angular_velocity == opuc_pkg::VEL_MAX || vel.angular_velocity == opuc_pkg::VEL_MIN,
    "clipped result has neither velocity at a limit")
  `OPUC_ASSERT_NEXT(a_last_stage_moves,
    s6_valid && !pose_stall,
    vel_valid,
    "item in the last stage did not reach the output register")
  `OPUC_ASSERT_NEXT(a_no_repeat,
    vel_valid && !vel_stall && !s6_valid,
    !vel_valid,
    "a transferred result was presented again")

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the offset-point unicycle controller unit.
`timescale 1ns / 1ps

module tb;
  import opuc_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD_CYCLES = 200;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  localparam int ATAN_TABLE[CORDIC_STAGES] = '{
    8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1
  };
  localparam int SPECIAL_HEADINGS[10] = '{
    0, 16384, -16384, 16385, -16385, 32767, -32768, 8192, -8192, 1
  };

  // Expected velocity commands for the poses that have been accepted.
  class vel_scoreboard;
    logic [GAIN_W-1:0]  gain = PROP_GAIN_RESET;
    logic [DIST_W-1:0]  distance = OFFSET_DIST_RESET;
    logic [RECIP_W-1:0] recip = OFFSET_RECIP_RESET;
    vel_t vel_expected_q[$];
    int errors = 0;

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_PROP_GAIN:    gain = data;
        REG_OFFSET_DIST:  distance = data[DIST_W-1:0];
        REG_OFFSET_RECIP: recip = data;
        default: ;
      endcase
    endfunction

    function longint round_down_shift(longint v, int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function longint clamp_word(longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (DATA_W - 1)) - 1;
      lo = -(longint'(1) <<< (DATA_W - 1));
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function vel_t expected_velocity(pose_t p);
      longint x, y, z, dx, dy, s, c;
      longint e0, e1, v0, v1, lin, rot, ang, lin_sat, ang_sat;
      bit flip;
      vel_t r;
      x = CORDIC_START;
      y = 0;
      z = longint'($signed(p.heading));
      flip = 1'b0;
      // Fold the far half turn onto the near one and negate the result.
      if (z > QUARTER_TURN) begin
        z -= HALF_TURN;
        flip = 1'b1;
      end else if (z < -QUARTER_TURN) begin
        z += HALF_TURN;
        flip = 1'b1;
      end
      for (int i = 0; i < CORDIC_STAGES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx;
          y += dy;
          z -= ATAN_TABLE[i];
        end else begin
          x += dx;
          y -= dy;
          z += ATAN_TABLE[i];
        end
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      c = (x > TRIG_ONE) ? TRIG_ONE : (x < -TRIG_ONE) ? -TRIG_ONE : x;
      s = (y > TRIG_ONE) ? TRIG_ONE : (y < -TRIG_ONE) ? -TRIG_ONE : y;

      e0 = longint'($signed(p.target_x)) - longint'($signed(p.pose_x))
           - round_down_shift(longint'(distance) * c, TRIG_FRAC);
      e1 = longint'($signed(p.target_y)) - longint'($signed(p.pose_y))
           - round_down_shift(longint'(distance) * s, TRIG_FRAC);
      v0 = round_down_shift(longint'(gain) * e0, 8);
      v1 = round_down_shift(longint'(gain) * e1, 8);
      lin = round_down_shift(c * v0 + s * v1, TRIG_FRAC);
      rot = round_down_shift(c * v1 - s * v0, TRIG_FRAC);
      ang = round_down_shift(rot * longint'(recip), 8);
      lin_sat = clamp_word(lin);
      ang_sat = clamp_word(ang);
      r.linear_velocity = lin_sat[DATA_W-1:0];
      r.angular_velocity = ang_sat[DATA_W-1:0];
      r.clipped = (lin_sat != lin) || (ang_sat != ang);
      return r;
    endfunction

    function void note_pose(pose_t p);
      vel_expected_q.push_back(expected_velocity(p));
    endfunction

    function void check_vel(vel_t got);
      vel_t want;
      if (vel_expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected velocity transfer: lin=%0d ang=%0d clipped=%0b",
                   $signed(got.linear_velocity), $signed(got.angular_velocity),
                   got.clipped);
        return;
      end
      want = vel_expected_q.pop_front();
      if (got.linear_velocity !== want.linear_velocity ||
          got.angular_velocity !== want.angular_velocity ||
          got.clipped !== want.clipped) begin
        errors++;
        if (errors <= 10)
          $display("velocity mismatch at %0t: expected lin=%0d ang=%0d clipped=%0b, %s",
                   $realtime, $signed(want.linear_velocity),
                   $signed(want.angular_velocity), want.clipped,
                   $sformatf("got lin=%0d ang=%0d clipped=%0b",
                             $signed(got.linear_velocity),
                             $signed(got.angular_velocity), got.clipped));
      end
    endfunction

    function int outstanding();
      return vel_expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic pose_valid;
  logic pose_stall;
  pose_t pose;
  logic vel_valid;
  logic vel_stall;
  vel_t vel;

  vel_scoreboard sb = new;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  bit long_hold_req = 1'b0;

  offset_point_unicycle_controller_unit DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .pose_valid(pose_valid),
    .pose_stall(pose_stall),
    .pose(pose),
    .vel_valid(vel_valid),
    .vel_stall(vel_stall),
    .vel(vel)
  );

  always #5 clk = ~clk;

  // Velocity side: per-transfer random stall, plus a long hold on request.
  initial begin : vel_sink
    int rx_wait;
    int hold_left;
    rx_wait = 0;
    hold_left = 0;
    vel_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && vel_valid && !vel_stall) begin
        sb.check_vel(vel);
        rx_wait = rx_idle ? $urandom_range(0, 9) : 0;
      end
      if (long_hold_req) begin
        hold_left = LONG_HOLD_CYCLES;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        vel_stall <= 1'b1;
      end else if (rx_wait > 0) begin
        rx_wait--;
        vel_stall <= 1'b1;
      end else begin
        vel_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("** offset_point_unicycle_controller_unit: FAILED **");
    $finish;
  end

  // Valid stays high into the next item when that item has no gap in front.
  task automatic send_pose(input pose_t p);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      pose_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pose_valid <= 1'b1;
    pose <= p;
    @(posedge clk);
    while (pose_stall) @(posedge clk);
    sb.note_pose(p);
  endtask

  task automatic wait_drained();
    pose_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_config(input logic [CFG_W-1:0] gain, input logic [CFG_W-1:0] distance,
                              input logic [CFG_W-1:0] recip, input bit poke_spare);
    logic [CFG_W-1:0] junk;
    cfg_write <= 1'b1;
    cfg_index <= REG_PROP_GAIN;
    cfg_data <= gain;
    @(posedge clk);
    sb.set_reg(REG_PROP_GAIN, gain);
    cfg_index <= REG_OFFSET_DIST;
    cfg_data <= distance;
    @(posedge clk);
    sb.set_reg(REG_OFFSET_DIST, distance);
    cfg_index <= REG_OFFSET_RECIP;
    cfg_data <= recip;
    @(posedge clk);
    sb.set_reg(REG_OFFSET_RECIP, recip);
    if (poke_spare) begin
      // An index past the last register must leave every register alone.
      junk = CFG_W'($urandom);
      cfg_index <= REG_SPARE;
      cfg_data <= junk;
      @(posedge clk);
      sb.set_reg(REG_SPARE, junk);
    end
    cfg_write <= 1'b0;
  endtask

  function automatic pose_t make_pose(int px, int py, int hd, int tx, int ty);
    pose_t p;
    p.pose_x = px[DATA_W-1:0];
    p.pose_y = py[DATA_W-1:0];
    p.heading = hd[ANGLE_W-1:0];
    p.target_x = tx[DATA_W-1:0];
    p.target_y = ty[DATA_W-1:0];
    return p;
  endfunction

  // Mostly positions within a few metres, so that results are not all clipped.
  function automatic int random_coord();
    int v;
    case ($urandom_range(0, 3))
      0:       v = $urandom;
      1:       v = $urandom_range(0, 16383) - 8192;
      default: v = $urandom_range(0, 4095) - 2048;
    endcase
    return v;
  endfunction

  function automatic pose_t random_pose();
    int hd;
    if ($urandom_range(0, 7) == 0)
      hd = SPECIAL_HEADINGS[$urandom_range(0, 9)];
    else
      hd = $urandom;
    return make_pose(random_coord(), random_coord(), hd, random_coord(), random_coord());
  endfunction

  task automatic settle();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] gain, input logic [CFG_W-1:0] distance,
                           input logic [CFG_W-1:0] recip, input int count,
                           input bit squeeze);
    settle();
    write_config(gain, distance, recip, 1'($urandom_range(0, 1)));
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        tx_idle = ($urandom_range(0, 3) != 0);
        rx_idle = ($urandom_range(0, 3) != 0);
      end
      if (squeeze && i == 100) begin
        // Hold the result side while poses keep coming, so the pipeline backs up.
        tx_idle = 1'b0;
        long_hold_req = 1'b1;
      end
      if (squeeze && i == 150)
        tx_idle = 1'b0;
      if (squeeze && i == 250)
        wait_drained();
      send_pose(random_pose());
    end
  endtask

  initial begin : stimulus
    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_PROP_GAIN;
    cfg_data <= '0;
    pose_valid <= 1'b0;
    pose <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Gain stays at its reset value of zero, so every command is zero.
    send_pose(make_pose(32767, -32768, 12345, -32768, 32767));
    send_pose(make_pose(-32768, 32767, -32768, 32767, -32768));
    send_pose(make_pose(1000, -2000, 16384, 3000, 4000));
    settle();

    write_config(16'd256, 16'd307, 16'd853, 1'b1);
    send_pose(make_pose(0, 0, 0, 0, 0));
    foreach (SPECIAL_HEADINGS[k])
      send_pose(make_pose(0, 0, SPECIAL_HEADINGS[k], 1024, 512));
    send_pose(make_pose(32767, 0, 0, -32768, 0));
    send_pose(make_pose(-32768, 0, 0, 32767, 0));
    send_pose(make_pose(0, 32767, 16384, 0, -32768));
    send_pose(make_pose(0, -32768, -16384, 0, 32767));

    run_phase(16'd256, 16'd307, 16'd853, 400, 1'b1);
    run_phase(16'hFFFF, 16'h7FFF, 16'hFFFF, 150, 1'b0);
    run_phase(16'd1, 16'd1, 16'd1, 150, 1'b0);
    run_phase(16'd0, 16'd0, 16'd0, 100, 1'b0);
    run_phase(16'd512, 16'd1024, 16'd256, 200, 1'b0);
    repeat (4)
      run_phase(CFG_W'($urandom_range(0, 1023)), CFG_W'($urandom), CFG_W'($urandom),
                200, 1'b0);
    run_phase(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom), 100, 1'b0);

    settle();
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("** offset_point_unicycle_controller_unit: PASSED **");
    end else begin
      $display("** offset_point_unicycle_controller_unit: FAILED **");
    end
    $finish;
  end

endmodule
